// File: hdl/srrip_pkg.sv
// Shared constants and types for the signature-based RRIP replacement block.
// No dependencies.
package srrip_pkg;

  localparam logic [1:0] OP_VICTIM = 2'd0;
  localparam logic [1:0] OP_HIT    = 2'd1;
  localparam logic [1:0] OP_FILL   = 2'd2;
  localparam logic [1:0] OP_SAMPLE = 2'd3;

  localparam logic [2:0] KIND_PREFETCH  = 3'd2;
  localparam logic [2:0] KIND_WRITEBACK = 3'd3;

  localparam logic [1:0] RRPV_MAX  = 2'd3;
  localparam logic [2:0] CTR_MAX   = 3'd7;
  localparam logic [2:0] CTR_INIT  = 3'd1;

  typedef struct packed {
    logic clr_en;
    logic rd_en;
    logic upd_en;
    logic upd_up;
  } ctr_req_t;

endpackage

// File: hdl/srrip_ctr.sv
// Signature history counter table with its saturating up/down unit.
// Depends on srrip_pkg.
module srrip_ctr #(
  parameter int unsigned DEPTH = 65536,
  parameter int unsigned AW    = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  srrip_pkg::ctr_req_t req_i,
  input  logic [AW-1:0]       addr_i,
  output logic [2:0]          rd_data_o
);

  logic [2:0]    mem [DEPTH];
  logic [2:0]    rd_q;
  logic [AW-1:0] addr_q;
  logic [2:0]    sat;

  always_comb begin
    if (req_i.upd_up) begin
      sat = (rd_q == srrip_pkg::CTR_MAX) ? rd_q : rd_q + 3'd1;
    end else begin
      sat = (rd_q == 3'd0) ? rd_q : rd_q - 3'd1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.clr_en) begin
      mem[addr_i] <= srrip_pkg::CTR_INIT;
    end else if (req_i.upd_en) begin
      mem[addr_q] <= sat;
    end
    if (req_i.rd_en) begin
      rd_q   <= mem[addr_i];
      addr_q <= addr_i;
    end
  end

  assign rd_data_o = rd_q;

`ifndef NO_ASSERTIONS
  a_no_mix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.clr_en |-> !req_i.upd_en && !req_i.rd_en)
    else $error("counter clear overlaps an access");
  a_upd_after_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.upd_en |-> $past(req_i.rd_en))
    else $error("counter update without a preceding read");
  a_rd_not_twice: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_i.rd_en |=> !req_i.rd_en)
    else $error("back-to-back counter reads");
`endif

endmodule

// File: hdl/ship_rrip_replacement.sv
// Signature-based RRIP replacement policy: each request runs through the row read, the
// sequencer's two serial reads of the one-port counter table, the write-back and the result
// register; a new request is taken only after the last result has entered the output register,
// and the sequencer waits while the output stalls. After reset a clearing pass over
// max(NUM_SETS*NUM_WAYS, NUM_CORES*TABLE_ENTRIES) entries runs before the first request is taken.
// NUM_SETS, NUM_WAYS and TABLE_ENTRIES are powers of two. Depends on srrip_pkg and srrip_ctr.
module ship_rrip_replacement #(
  parameter int unsigned NUM_SETS      = 8192,
  parameter int unsigned NUM_WAYS      = 16,
  parameter int unsigned NUM_CORES     = 4,
  parameter int unsigned TABLE_ENTRIES = 16384
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  // core[1:0], set_index[14:2], way_index[18:15], pc_low[31:19], train_chance[32]
  input  logic [39:0] s_axis_tdata_i,
  // opcode[1:0], access_kind[4:2]
  input  logic [4:0]  s_axis_tuser_i,
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  // victim_way[3:0], line_priority[5:4]
  output logic [7:0]  m_axis_tdata_o
);

  localparam int unsigned SET_W  = $clog2(NUM_SETS);
  localparam int unsigned WAY_W  = $clog2(NUM_WAYS);
  localparam int unsigned CORE_W = (NUM_CORES > 1) ? $clog2(NUM_CORES) : 1;
  localparam int unsigned SIG_W  = $clog2(TABLE_ENTRIES);
  localparam int unsigned LINE_W = SET_W + WAY_W;
  localparam int unsigned LINES  = NUM_SETS * NUM_WAYS;
  localparam int unsigned CTRS   = NUM_CORES * TABLE_ENTRIES;
  localparam int unsigned CTR_AW = CORE_W + SIG_W;
  localparam int unsigned INFO_W = 2 + SIG_W + CORE_W;
  localparam int unsigned CLR_N  = (LINES > CTRS) ? LINES : CTRS;
  localparam int unsigned CLR_W  = $clog2(CLR_N);
  localparam int unsigned ROW_W  = 2 * NUM_WAYS;

  typedef enum logic [2:0] {
    S_CLEAR, S_IDLE, S_RD, S_LD, S_UPD, S_NEW, S_WB, S_OUT
  } state_e;

  state_e            state_q;
  logic [CLR_W-1:0]  clr_q;
  logic [1:0]        op_q;
  logic [2:0]        kind_q;
  logic [CORE_W-1:0] core_q;
  logic [SET_W-1:0]  set_q;
  logic [WAY_W-1:0]  way_q;
  logic [SIG_W-1:0]  nsig_q;
  logic              chance_q;
  logic [3:0]        res_way_q;
  logic [1:0]        res_prio_q;
  logic              m_valid_q;
  logic [7:0]        m_data_q;

  logic [ROW_W-1:0]  rrpv_mem [NUM_SETS];
  logic [INFO_W-1:0] info_mem [LINES];
  logic              samp_mem [NUM_SETS];
  logic [ROW_W-1:0]  row_q;
  logic [INFO_W-1:0] info_q;
  logic              samp_q;

  logic [1:0]        core_red;
  logic [31:0]       core_ext, set_ext, way_ext, sig_ext;
  logic              accept;
  logic [LINE_W-1:0] line_idx;
  logic              in_pf, is_wb;
  logic              l_pf, l_reused;
  logic [SIG_W-1:0]  l_sig;
  logic [CORE_W-1:0] l_core;
  logic              train, train_up, pf_rehit;
  srrip_pkg::ctr_req_t ctr_req;
  logic [CTR_AW-1:0] ctr_addr;
  logic [2:0]        ctr_data;
  logic [1:0]        top, delta, cur, new_prio;
  logic [ROW_W-1:0]  aged, row_d;
  logic [WAY_W-1:0]  vic;
  logic [INFO_W-1:0] info_d;
  logic              vic_found;

  always_comb begin
    core_red = s_axis_tdata_i[1:0];
    for (int k = 0; k < 3; k++) begin
      if (32'(core_red) >= NUM_CORES) begin
        core_red = 2'(32'(core_red) - NUM_CORES);
      end
    end
  end

  assign core_ext = 32'(core_red);
  assign set_ext  = 32'(s_axis_tdata_i[14:2]);
  assign way_ext  = 32'(s_axis_tdata_i[18:15]);
  assign sig_ext  = 32'({s_axis_tdata_i[31:19],
                         s_axis_tuser_i[4:2] == srrip_pkg::KIND_PREFETCH});

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;
  assign line_idx        = {set_q, way_q};
  assign in_pf           = (kind_q == srrip_pkg::KIND_PREFETCH);
  assign is_wb           = (kind_q == srrip_pkg::KIND_WRITEBACK);

  assign l_pf     = info_q[0];
  assign l_reused = info_q[1];
  assign l_sig    = info_q[2 +: SIG_W];
  assign l_core   = info_q[2 + SIG_W +: CORE_W];
  assign pf_rehit = in_pf && l_pf;

  always_comb begin
    train    = 1'b0;
    train_up = 1'b1;
    if (op_q == srrip_pkg::OP_HIT && !is_wb) begin
      train = pf_rehit ? (samp_q && chance_q) : (samp_q && !l_reused);
    end else if (op_q == srrip_pkg::OP_FILL) begin
      train    = samp_q;
      train_up = l_reused;
    end
  end

  always_comb begin
    ctr_req = '0;
    ctr_addr = {l_core, l_sig};
    case (state_q)
      S_CLEAR: begin
        ctr_req.clr_en = (32'(clr_q) < CTRS);
        ctr_addr = clr_q[CTR_AW-1:0];
      end
      S_LD: ctr_req.rd_en = 1'b1;
      S_UPD: begin
        ctr_req.upd_en = train;
        ctr_req.upd_up = train_up;
      end
      S_NEW: begin
        ctr_req.rd_en = 1'b1;
        ctr_addr = {core_q, nsig_q};
      end
      default: ctr_req = '0;
    endcase
  end

  srrip_ctr #(.DEPTH(CTRS), .AW(CTR_AW)) u_ctr (
    .clk_i,
    .rst_ni,
    .req_i     (ctr_req),
    .addr_i    (ctr_addr),
    .rd_data_o (ctr_data)
  );

  always_comb begin
    top = 2'd0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      if (row_q[2*i +: 2] > top) top = row_q[2*i +: 2];
    end
    delta = srrip_pkg::RRPV_MAX - top;
    vic = '0;
    vic_found = 1'b0;
    for (int i = 0; i < NUM_WAYS; i++) begin
      aged[2*i +: 2] = row_q[2*i +: 2] + delta;
      if (!vic_found && aged[2*i +: 2] == srrip_pkg::RRPV_MAX) begin
        vic = WAY_W'(i);
        vic_found = 1'b1;
      end
    end
  end

  always_comb begin
    cur      = row_q[2*way_q +: 2];
    new_prio = cur;
    info_d   = info_q;
    row_d    = row_q;
    case (op_q)
      srrip_pkg::OP_VICTIM: begin
        row_d = aged;
        new_prio = srrip_pkg::RRPV_MAX;
      end
      srrip_pkg::OP_HIT: begin
        if (!is_wb) begin
          if (!pf_rehit) begin
            new_prio  = l_pf ? srrip_pkg::RRPV_MAX : 2'd0;
            info_d[0] = 1'b0;
          end
          if (train) info_d[1] = 1'b1;
        end
      end
      srrip_pkg::OP_FILL: begin
        info_d[0] = in_pf;
        if (samp_q) begin
          info_d[1] = 1'b0;
          info_d[2 +: SIG_W] = nsig_q;
          info_d[2 + SIG_W +: CORE_W] = core_q;
        end
        if (is_wb || ctr_data == 3'd0) begin
          new_prio = srrip_pkg::RRPV_MAX;
        end else if (ctr_data == srrip_pkg::CTR_MAX) begin
          new_prio = in_pf ? 2'd1 : 2'd0;
        end else begin
          new_prio = 2'd2;
        end
      end
      default: new_prio = cur;
    endcase
    if (op_q == srrip_pkg::OP_HIT || op_q == srrip_pkg::OP_FILL) begin
      row_d[2*way_q +: 2] = new_prio;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_CLEAR) begin
      if (32'(clr_q) < NUM_SETS) begin
        rrpv_mem[clr_q[SET_W-1:0]] <= '1;
        samp_mem[clr_q[SET_W-1:0]] <= 1'b0;
      end
      if (32'(clr_q) < LINES) begin
        info_mem[clr_q[LINE_W-1:0]] <= '0;
      end
    end else if (state_q == S_WB) begin
      rrpv_mem[set_q] <= row_d;
      info_mem[line_idx] <= info_d;
      if (op_q == srrip_pkg::OP_SAMPLE) samp_mem[set_q] <= 1'b1;
    end
    if (state_q == S_RD) begin
      row_q  <= rrpv_mem[set_q];
      info_q <= info_mem[line_idx];
      samp_q <= samp_mem[set_q];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      m_valid_q <= 1'b0;
    end else begin
      if (m_valid_q && m_axis_tready_i && state_q != S_OUT) m_valid_q <= 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (32'(clr_q) == CLR_N - 1) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (accept) begin
            op_q     <= s_axis_tuser_i[1:0];
            kind_q   <= s_axis_tuser_i[4:2];
            core_q   <= core_ext[CORE_W-1:0];
            set_q    <= set_ext[SET_W-1:0];
            way_q    <= way_ext[WAY_W-1:0];
            nsig_q   <= sig_ext[SIG_W-1:0];
            chance_q <= s_axis_tdata_i[32];
            state_q  <= S_RD;
          end
        end
        S_RD:  state_q <= S_LD;
        S_LD:  state_q <= S_UPD;
        S_UPD: state_q <= S_NEW;
        S_NEW: state_q <= S_WB;
        S_WB: begin
          res_way_q  <= (op_q == srrip_pkg::OP_VICTIM) ? 4'(vic) : 4'd0;
          res_prio_q <= new_prio;
          state_q    <= S_OUT;
        end
        S_OUT: begin
          if (!m_valid_q || m_axis_tready_i) begin
            m_valid_q <= 1'b1;
            m_data_q  <= {2'b00, res_prio_q, res_way_q};
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = m_data_q;

`ifndef NO_ASSERTIONS
  a_victim_prio: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WB && op_q == srrip_pkg::OP_VICTIM) |=> res_prio_q == srrip_pkg::RRPV_MAX)
    else $error("victim line not at distant priority");
  a_accept_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_RD)
    else $error("request did not start the sequence");
  a_upd_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ctr_req.upd_en |-> state_q == S_UPD)
    else $error("counter update outside its step");
  a_out_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready_i) |=> m_valid_q)
    else $error("pending result dropped");
`endif

endmodule
